@@ hw/rtl/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES          = 65536;
    localparam int WORD_BITS          = 32;
    localparam int LOW_RESERVED_PAGES = 256;
    localparam int PAGE_BYTES         = 4096;

    localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int PTR_W      = WORD_AW + 1;
    localparam int COUNT_W    = 17;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
    localparam int MEM_KIB_W  = 22;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_KIB   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_END = 1'b1;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_RD,
        S_FREE_CHK,
        S_INIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic alloc_rd;
        logic alloc_take;
        logic alloc_next;
        logic free_rd;
        logic free_take;
        logic init_step;
        logic set_oom;
        logic set_bad;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        logic map_built;
        logic ptr_end;
        logic word_full;
        logic range_bad;
        logic page_free;
        logic init_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/bpa_ram.sv @@
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpa_ctrl.sv @@
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_kind,
    output logic            o_in_stall,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_kind'(i_kind))
                        KIND_ALLOC: n_state = S_ALLOC_RD;
                        KIND_FREE:  n_state = S_FREE_RD;
                        KIND_INIT:  n_state = S_INIT;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_ALLOC_RD: begin
                if (!i_sts.map_built || i_sts.ptr_end) begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.alloc_rd = 1'b1;
                    n_state        = S_ALLOC_CHK;
                end
            end
            S_ALLOC_CHK: begin
                if (i_sts.word_full) begin
                    o_cmd.alloc_next = 1'b1;
                    n_state          = S_ALLOC_RD;
                end else begin
                    o_cmd.alloc_take = 1'b1;
                    n_state          = S_RESP;
                end
            end
            S_FREE_RD: begin
                if (i_sts.range_bad) begin
                    o_cmd.set_bad = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.free_rd = 1'b1;
                    n_state       = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (i_sts.page_free) begin
                    o_cmd.set_bad = 1'b1;
                end else begin
                    o_cmd.free_take = 1'b1;
                end
                n_state = S_RESP;
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpa_datapath.sv @@
`default_nettype none

module bpa_datapath import bpa_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [1:0]             i_kind,
    input  wire logic [ADDR_W-1:0]      i_address,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_out_stall,
    output logic                        o_out_valid,
    output logic [ADDR_W-1:0]           o_page_address,
    output logic [1:0]                  o_status,
    output logic [COUNT_W-1:0]          o_free_count,
    output logic [COUNT_W-1:0]          o_total_count,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts
);

    logic [MEM_KIB_W-1:0]  r_memory_kib;
    logic [ADDR_W-1:0]     r_reserved_end;
    logic [COUNT_W-1:0]    r_total;
    logic [COUNT_W-1:0]    r_free;
    logic [COUNT_W-1:0]    r_start;
    logic [PTR_W-1:0]      r_hint;
    logic [PTR_W-1:0]      r_ptr;
    logic                  r_built;
    logic [PAGE_NUM_W-1:0] r_page;
    logic [ADDR_W-1:0]     r_res_addr;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_out_addr;
    logic [1:0]            r_out_status;
    logic [COUNT_W-1:0]    r_out_free;
    logic [COUNT_W-1:0]    r_out_total;

    logic [PAGE_NUM_W-1:0] w_pages_raw;
    logic [COUNT_W-1:0]    w_total;
    logic [ADDR_W:0]       w_round;
    logic [ADDR_W-PAGE_SHIFT:0] w_first;
    logic [ADDR_W-PAGE_SHIFT:0] w_first_c;
    logic [COUNT_W-1:0]    w_start;

    logic                  w_we;
    logic [WORD_AW-1:0]    w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic                  w_re;
    logic [WORD_AW-1:0]    w_raddr;
    logic [WORD_BITS-1:0]  w_rdata;
    logic [WORD_BITS-1:0]  w_init_word;
    logic [BIT_AW-1:0]     w_zero_idx;
    logic [WORD_AW-1:0]    w_page_word;

    assign w_page_word = r_page[BIT_AW +: WORD_AW];

    always_comb begin
        w_pages_raw = r_memory_kib[MEM_KIB_W-1:2];
        w_total     = (w_pages_raw > PAGE_NUM_W'(NUM_PAGES)) ? COUNT_W'(NUM_PAGES)
                                                              : w_pages_raw[COUNT_W-1:0];
        w_round     = {1'b0, r_reserved_end} + (ADDR_W+1)'(PAGE_BYTES - 1);
        w_first     = w_round[ADDR_W:PAGE_SHIFT];
        w_first_c   = (w_first < (PAGE_NUM_W+1)'(LOW_RESERVED_PAGES))
                    ? (PAGE_NUM_W+1)'(LOW_RESERVED_PAGES) : w_first;
        w_start     = (w_first_c < (PAGE_NUM_W+1)'(w_total)) ? w_first_c[COUNT_W-1:0]
                                                             : w_total;
    end

    always_comb begin
        logic [COUNT_W-1:0] v_pg;
        v_pg = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            v_pg = {1'b0, r_ptr[WORD_AW-1:0], BIT_AW'(b)};
            w_init_word[b] = !((v_pg >= r_start) && (v_pg < r_total));
        end
    end

    always_comb begin
        w_zero_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w_rdata[b]) begin
                w_zero_idx = BIT_AW'(b);
            end
        end
    end

    always_comb begin
        w_we    = i_cmd.init_step | i_cmd.alloc_take | i_cmd.free_take;
        w_waddr = i_cmd.free_take ? w_page_word : r_ptr[WORD_AW-1:0];
        if (i_cmd.init_step) begin
            w_wdata = w_init_word;
        end else if (i_cmd.alloc_take) begin
            w_wdata = w_rdata | (WORD_BITS'(1) << w_zero_idx);
        end else begin
            w_wdata = w_rdata & ~(WORD_BITS'(1) << r_page[BIT_AW-1:0]);
        end
        w_re    = i_cmd.alloc_rd | i_cmd.free_rd;
        w_raddr = i_cmd.free_rd ? w_page_word : r_ptr[WORD_AW-1:0];
    end

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_kib   <= '0;
            r_reserved_end <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MEMORY_KIB) begin
                r_memory_kib <= i_cfg_data[MEM_KIB_W-1:0];
            end else if (i_cfg_index == CFG_RESERVED_END) begin
                r_reserved_end <= i_cfg_data[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_free  <= '0;
            r_hint  <= '0;
            r_ptr   <= '0;
            r_built <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (t_kind'(i_kind) == KIND_INIT) begin
                    r_total <= w_total;
                    r_free  <= w_total - w_start;
                    r_hint  <= w_start[COUNT_W-1:BIT_AW];
                    r_ptr   <= '0;
                    r_built <= 1'b1;
                end else begin
                    r_ptr <= r_hint;
                end
            end
            if (i_cmd.init_step || i_cmd.alloc_next) begin
                r_ptr <= r_ptr + PTR_W'(1);
            end
            if (i_cmd.alloc_take) begin
                r_hint <= r_ptr;
                if (r_free != '0) begin
                    r_free <= r_free - COUNT_W'(1);
                end
            end
            if (i_cmd.set_oom) begin
                r_hint <= r_ptr;
            end
            if (i_cmd.free_take) begin
                r_free <= r_free + COUNT_W'(1);
                if ({1'b0, w_page_word} < r_hint) begin
                    r_hint <= {1'b0, w_page_word};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page       <= i_address[ADDR_W-1:PAGE_SHIFT];
            r_res_addr   <= '0;
            r_res_status <= ST_OK;
            if (t_kind'(i_kind) == KIND_INIT) begin
                r_start <= w_start;
            end
        end
        if (i_cmd.alloc_take) begin
            r_res_addr <= ADDR_W'({r_ptr[WORD_AW-1:0], w_zero_idx, PAGE_SHIFT'(0)});
        end
        if (i_cmd.set_oom) begin
            r_res_status <= ST_OOM;
        end
        if (i_cmd.set_bad) begin
            r_res_status <= ST_BAD_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.respond) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
            r_out_free   <= r_free;
            r_out_total  <= r_total;
        end
    end

    always_comb begin
        o_sts.map_built = r_built;
        o_sts.ptr_end   = r_ptr[WORD_AW];
        o_sts.word_full = (w_rdata == {WORD_BITS{1'b1}});
        o_sts.range_bad = (r_page >= PAGE_NUM_W'(r_total));
        o_sts.page_free = !w_rdata[r_page[BIT_AW-1:0]];
        o_sts.init_last = (r_ptr[WORD_AW-1:0] == WORD_AW'(MAP_WORDS - 1));
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;
    assign o_free_count   = r_out_free;
    assign o_total_count  = r_out_total;

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_allocator.sv @@
// One transaction is in flight at a time; the input stalls while it is processed and
// until its result has been loaded into the output register. The alloc scan reads map
// words in turn from a hint word that tracks the lowest word that can hold a free page;
// init writes all 2048 map words.
// Reset (synchronous, active low) clears config, counts, hint and handshake state.
// Map contents are undefined until the first init; alloc before it reports out of memory.
`default_nettype none

module bitmap_page_allocator import bpa_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_kind,
    input  wire logic [ADDR_W-1:0]      i_address,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [ADDR_W-1:0]           o_page_address,
    output logic [1:0]                  o_status,
    output logic [COUNT_W-1:0]          o_free_count,
    output logic [COUNT_W-1:0]          o_total_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .o_free_count   (o_free_count),
        .o_total_count  (o_total_count),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import bpa_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 100;

    typedef struct {
        logic [ADDR_W-1:0]  page_address;
        logic [1:0]         status;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] total_count;
    } t_page_result;

    logic                   i_clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [1:0]             kind        = '0;
    logic [ADDR_W-1:0]      address     = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [ADDR_W-1:0]      out_page_address;
    logic [1:0]             out_status;
    logic [COUNT_W-1:0]     out_free_count;
    logic [COUNT_W-1:0]     out_total_count;

    bitmap_page_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_address      (address),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_page_address (out_page_address),
        .o_status       (out_status),
        .o_free_count   (out_free_count),
        .o_total_count  (out_total_count)
    );

    // allocator image: map, counts and registers
    bit                 page_used [NUM_PAGES];
    int                 img_free         = 0;
    int                 img_total        = 0;
    int                 scan_from        = 0;
    logic [MEM_KIB_W-1:0] mem_kib_reg    = '0;
    logic [ADDR_W-1:0]  reserved_end_reg = '0;

    t_page_result pending_results [$];
    int           mismatches   = 0;
    int           burst_left   = 0;
    int           quiet_cycles = 0;
    int           stall_mode   = 0;
    int           mode_left    = 0;
    logic [2:0]   pat_cnt      = '0;
    logic         holding      = 1'b0;
    event         hold_ev;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        foreach (page_used[i]) page_used[i] = 1'b1;
    end

    function automatic t_page_result apply_request(input logic [1:0] k,
                                                   input logic [ADDR_W-1:0] a);
        t_page_result r;
        int           p;
        int           span;
        longint       start;
        r.page_address = '0;
        r.status       = ST_OK;
        case (k)
            KIND_ALLOC: begin
                p = scan_from;
                while (p < NUM_PAGES && page_used[p]) p++;
                if (p < NUM_PAGES) begin
                    page_used[p] = 1'b1;
                    if (img_free > 0) img_free--;
                    r.page_address = ADDR_W'(p) << PAGE_SHIFT;
                    scan_from = p + 1;
                end else begin
                    r.status = ST_OOM;
                    scan_from = NUM_PAGES;
                end
            end
            KIND_FREE: begin
                p = int'(a >> PAGE_SHIFT);
                if (p >= img_total || !page_used[p]) begin
                    r.status = ST_BAD_FREE;
                end else begin
                    page_used[p] = 1'b0;
                    img_free++;
                    if (p < scan_from) scan_from = p;
                end
            end
            KIND_INIT: begin
                span = mem_kib_reg / 4;
                if (span > NUM_PAGES) span = NUM_PAGES;
                img_total = span;
                img_free  = 0;
                foreach (page_used[i]) page_used[i] = 1'b1;
                start = ({32'd0, reserved_end_reg} + PAGE_BYTES - 1) >> PAGE_SHIFT;
                if (start < LOW_RESERVED_PAGES) start = LOW_RESERVED_PAGES;
                if (start > img_total) start = img_total;
                for (int q = int'(start); q < img_total; q++) begin
                    page_used[q] = 1'b0;
                    img_free++;
                end
                scan_from = int'(start);
            end
            default: begin
            end
        endcase
        r.free_count  = COUNT_W'(img_free);
        r.total_count = COUNT_W'(img_total);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] page_to_address(input int p);
        return (ADDR_W'(p) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
    endfunction

    function automatic int pick_used_page();
        int p;
        p = 0;
        for (int t = 0; t < 8; t++) begin
            p = (img_total == 0) ? 0 : $urandom_range(0, img_total - 1);
            if (page_used[p]) break;
        end
        return p;
    endfunction

    function automatic void check_field(input string field, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [ADDR_W-1:0] a,
                             output t_page_result res);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 19);
            gap = (gap < 14) ? $urandom_range(1, 3) :
                  (gap < 19) ? $urandom_range(4, 12) : $urandom_range(20, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        address  <= a;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        res = apply_request(k, a);
        pending_results.push_back(res);
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        if (idx == CFG_MEMORY_KIB) mem_kib_reg = d[MEM_KIB_W-1:0];
        else reserved_end_reg = d;
    endtask

    task automatic set_config(input logic [MEM_KIB_W-1:0] kib,
                              input logic [ADDR_W-1:0] res_end);
        logic [CFG_DATA_W-1:0] d;
        d = $urandom();
        d[MEM_KIB_W-1:0] = kib;
        wait_idle();
        cfg_write(CFG_MEMORY_KIB, d);
        cfg_write(CFG_RESERVED_END, res_end);
        cfg_we <= 1'b0;
    endtask

    task automatic test_before_init();
        t_page_result res;
        send_item(KIND_ALLOC, 32'h0, res);
        send_item(KIND_FREE, 32'h0, res);
        send_item(KIND_FREE, 32'hFFFF_FFFF, res);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF, res);
    endtask

    task automatic test_directed();
        t_page_result res;
        set_config(MEM_KIB_W'(1200), 32'h0);
        send_item(KIND_INIT, 32'h0, res);
        send_item(KIND_ALLOC, 32'h0, res);
        send_item(KIND_FREE, 32'h0010_0ABC, res);
        send_item(KIND_FREE, 32'h0010_0000, res);
        send_item(KIND_FREE, 32'h0000_5FFF, res);
        send_item(KIND_ALLOC, 32'h0, res);
        send_item(KIND_FREE, 32'h0012_C000, res);
        send_item(KIND_FREE, 32'hFFFF_F000, res);
        send_item(KIND_UNUSED, 32'h0, res);

        set_config(MEM_KIB_W'(1203), 32'h0012_3001);
        send_item(KIND_INIT, 32'h0, res);
        repeat (9) send_item(KIND_ALLOC, 32'h0, res);
        send_item(KIND_FREE, 32'h0012_3000, res);

        set_config('1, 32'hFFFF_FFFF);
        send_item(KIND_INIT, 32'hFFFF_FFFF, res);
        send_item(KIND_ALLOC, 32'h0, res);

        set_config('0, 32'h0010_0000);
        send_item(KIND_INIT, 32'h0, res);
        send_item(KIND_FREE, 32'h0, res);
        send_item(KIND_ALLOC, 32'h0, res);
    endtask

    task automatic test_stall_pressure();
        t_page_result res;
        set_config(MEM_KIB_W'(2000), 32'h0);
        send_item(KIND_INIT, 32'h0, res);
        wait_idle();
        -> hold_ev;
        for (int n = 0; n < 16; n++)
            send_item((n % 3 == 2) ? KIND_FREE : KIND_ALLOC,
                      page_to_address(pick_used_page()), res);
    endtask

    task automatic test_fill_and_drain();
        t_page_result res;
        int           guard;
        for (int round = 0; round < 3; round++) begin
            set_config(MEM_KIB_W'($urandom_range(257, 330) * 4 + $urandom_range(0, 3)),
                       ADDR_W'($urandom_range(0, 300 * PAGE_BYTES)));
            send_item(KIND_INIT, $urandom(), res);
            guard = 0;
            do begin
                send_item(KIND_ALLOC, $urandom(), res);
                guard++;
            end while (res.status != ST_OOM && guard < 200);
            for (int n = 0; n < 40; n++)
                send_item(KIND_FREE, page_to_address(pick_used_page()), res);
            for (int n = 0; n < 30; n++) begin
                if ($urandom_range(0, 1))
                    send_item(KIND_ALLOC, $urandom(), res);
                else
                    send_item(KIND_FREE, page_to_address($urandom_range(0, img_total + 4)),
                              res);
            end
        end
    endtask

    task automatic test_random_traffic();
        t_page_result         res;
        logic [MEM_KIB_W-1:0] kib;
        logic [ADDR_W-1:0]    res_end;
        int                   sel;
        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 7))
                0:       kib = '0;
                1:       kib = '1;
                2:       kib = MEM_KIB_W'($urandom());
                default: kib = MEM_KIB_W'($urandom_range(256, 700) * 4 + $urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 7))
                0:       res_end = '0;
                1:       res_end = '1;
                2:       res_end = $urandom();
                default: res_end = ADDR_W'($urandom_range(0, 700 * PAGE_BYTES));
            endcase
            set_config(kib, res_end);
            if ($urandom_range(0, 9) != 0) send_item(KIND_INIT, $urandom(), res);
            for (int n = 0; n < 60; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    send_item(KIND_ALLOC, $urandom(), res);
                else if (sel < 75)
                    send_item(KIND_FREE, page_to_address(pick_used_page()), res);
                else if (sel < 88)
                    send_item(KIND_FREE, page_to_address($urandom_range(0, img_total + 8)),
                              res);
                else if (sel < 94)
                    send_item(KIND_FREE, $urandom(), res);
                else if (sel < 97)
                    send_item(KIND_UNUSED, $urandom(), res);
                else
                    send_item(KIND_INIT, $urandom(), res);
            end
        end
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_page_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, page_address %0d", out_page_address);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("page_address", want.page_address, out_page_address);
                check_field("status", ADDR_W'(want.status), ADDR_W'(out_status));
                check_field("free_count", ADDR_W'(want.free_count), ADDR_W'(out_free_count));
                check_field("total_count", ADDR_W'(want.total_count),
                            ADDR_W'(out_total_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        pat_cnt <= pat_cnt + 1'b1;
        if (holding) begin
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 40);
                2:       out_stall <= (pat_cnt < 3'd3);
                default: out_stall <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    initial begin
        forever begin
            @(hold_ev);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_init();
        test_directed();
        test_stall_pressure();
        test_fill_and_drain();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
